// ===== src/mts_pkg.sv =====
package mts_pkg;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned CountW     = 9;

  typedef enum logic [0:0] {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_FILL = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    mode_e                     mode;
    logic signed [ValueW-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0]  top_value;
    logic signed [ValueW-1:0]  min_value;
    logic [CountW-1:0]         count;
    status_e                   status;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic fill;
  } mts_cmd_t;

  typedef struct packed {
    logic needs_fill;
    logic out_busy;
  } mts_status_t;

endpackage

// ===== src/mts_ctrl.sv =====
module mts_ctrl
  import mts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        out_ready_i,
  input  mts_status_t status_i,
  output logic        in_ready_o,
  output mts_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = !status_i.out_busy || out_ready_i;
        cmd_o.accept = in_valid_i && in_ready_o;
        if (cmd_o.accept && status_i.needs_fill) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mts_datapath.sv =====
module mts_datapath
  import mts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mts_cmd_t    cmd_i,
  input  in_item_t    in_item_i,
  input  logic        out_ready_i,
  output mts_status_t status_o,
  output logic        out_valid_o,
  output out_item_t   out_item_o
);

  logic signed [ValueW-1:0] value_mem [StackDepth];
  logic signed [ValueW-1:0] min_mem   [StackDepth];

  logic [CntW-1:0]          cnt_q, cnt_d, mcnt_q, mcnt_d;
  logic signed [ValueW-1:0] top_q, top_d, min_q, min_d;
  logic signed [ValueW-1:0] vrd_q, mrd_q;
  logic [AddrW-1:0]         vaddr, maddr;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_q, out_d;
  logic                     push_ok, push_min, pop_ok, load_out;
  status_e                  status;

  assign push_ok  = cmd_i.accept && (in_item_i.mode == MODE_PUSH)
                    && (cnt_q < CntW'(StackDepth));
  assign push_min = push_ok && ((mcnt_q == '0) || (in_item_i.value <= min_q));
  assign pop_ok   = cmd_i.accept && (in_item_i.mode == MODE_POP) && (cnt_q != '0);

  assign status_o.needs_fill = (in_item_i.mode == MODE_POP) && (cnt_q != '0);
  assign status_o.out_busy   = out_valid_q;

  always_comb begin
    cnt_d  = cnt_q;
    mcnt_d = mcnt_q;
    top_d  = top_q;
    min_d  = min_q;
    status = STATUS_OK;
    if (cmd_i.fill) begin
      top_d = vrd_q;
      min_d = mrd_q;
    end else if (cmd_i.accept) begin
      if (in_item_i.mode == MODE_PUSH) begin
        if (push_ok) begin
          cnt_d = cnt_q + 1'b1;
          top_d = in_item_i.value;
          if (push_min) begin
            mcnt_d = mcnt_q + 1'b1;
            min_d  = in_item_i.value;
          end
        end else begin
          status = STATUS_OVERFLOW;
        end
      end else begin
        if (pop_ok) begin
          cnt_d = cnt_q - 1'b1;
          if ((mcnt_q != '0) && (min_q == top_q)) begin
            mcnt_d = mcnt_q - 1'b1;
          end
        end else begin
          status = STATUS_UNDERFLOW;
        end
      end
    end
  end

  assign vaddr = AddrW'(cnt_q - CntW'(2));
  assign maddr = AddrW'(mcnt_d - 1'b1);

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      value_mem[cnt_q[AddrW-1:0]] <= in_item_i.value;
    end
    if (push_min) begin
      min_mem[mcnt_q[AddrW-1:0]] <= in_item_i.value;
    end
    vrd_q <= value_mem[vaddr];
    mrd_q <= min_mem[maddr];
  end

  assign load_out = cmd_i.fill || (cmd_i.accept && !pop_ok);

  always_comb begin
    out_d.top_value = (cnt_d != '0) ? top_d : '0;
    out_d.min_value = (mcnt_d != '0) ? min_d : '0;
    out_d.count     = CountW'(cnt_d);
    out_d.status    = status;
    out_valid_d     = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      mcnt_q      <= mcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    min_q <= min_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/min_tracking_stack.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   in_item_i  (mode, value)
// out      output     out_valid_o/out_ready_i out_item_o (top_value, min_value, count, status)
//
// A push, an overflowing push or an underflowing pop completes when it is
// accepted; a pop that removes an entry goes on through the fill state, as
// the new tops come from the stack memories' registered read port.
// Reset empties both stacks at once; no clearing pass is run.
// A new item is taken once no fill is pending and the result register is empty or being drained.
module min_tracking_stack
  import mts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  mts_cmd_t    cmd;
  mts_status_t status;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  mts_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
